>>> hw/rtl/edb_pkg.sv
// Shared types, constants and helper functions of the error diffusion binarizer.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package edb_pkg;

  localparam int SAMP_W     = 8;
  localparam int FRAC_W     = 6;
  localparam int ERR_W      = FRAC_W + 11;
  localparam int WIDE_W     = ERR_W + 7;
  localparam int NUM_CH     = 3;
  localparam int CH_W       = 2;
  localparam int MAX_LW     = 1024;
  localparam int COL_W      = 10;
  localparam int LW_W       = 11;
  localparam int THR_W      = 8;
  localparam int WGT_W      = 4;
  localparam int TOT_W      = 7;
  localparam int MAG_W      = ERR_W + 3;
  localparam int QUO_W      = MAG_W + 1;
  localparam int DIV_STEPS  = MAG_W;
  localparam int STEP_W     = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;
  localparam int NUM_LANES  = 4;

  localparam logic signed [ERR_W-1:0] ERR_MAX = {1'b0, {(ERR_W-1){1'b1}}};
  localparam logic signed [ERR_W-1:0] ERR_MIN = {1'b1, {(ERR_W-1){1'b0}}};
  localparam logic [SAMP_W+FRAC_W-1:0] WHITE  = (SAMP_W+FRAC_W)'(255 << FRAC_W);

  // Divider lanes: one per neighbour share.
  localparam int LANE_RIGHT      = 0;
  localparam int LANE_DOWN_LEFT  = 1;
  localparam int LANE_DOWN       = 2;
  localparam int LANE_DOWN_RIGHT = 3;

  typedef struct packed {
    logic [SAMP_W-1:0] red_or_gray;
    logic [SAMP_W-1:0] green;
    logic [SAMP_W-1:0] blue;
    logic              frame_start;
  } in_word_t;

  typedef struct packed {
    logic red_or_gray_bit;
    logic green_bit;
    logic blue_bit;
  } out_word_t;

  typedef struct packed {
    logic [THR_W-1:0] threshold;
    logic [LW_W-1:0]  line_width;
    logic             color_mode;
    logic [WGT_W-1:0] weight_right;
    logic [WGT_W-1:0] weight_down_left;
    logic [WGT_W-1:0] weight_down;
    logic [WGT_W-1:0] weight_down_right;
    logic [TOT_W-1:0] weight_total;
  } cfg_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD         = 3'd0,
    CFG_LINE_WIDTH        = 3'd1,
    CFG_COLOR_MODE        = 3'd2,
    CFG_WEIGHT_RIGHT      = 3'd3,
    CFG_WEIGHT_DOWN_LEFT  = 3'd4,
    CFG_WEIGHT_DOWN       = 3'd5,
    CFG_WEIGHT_DOWN_RIGHT = 3'd6,
    CFG_WEIGHT_TOTAL      = 3'd7
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADJ,
    ST_MUL,
    ST_DIV,
    ST_WRA,
    ST_WRB,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic accept;
    logic adjust;
    logic load;
    logic step;
    logic write_left;
    logic write_here;
    logic next_ch;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic last_ch;
    logic out_free;
  } sts_t;

  // Clamp a widened signed value to the error range.
  function automatic logic signed [ERR_W-1:0] sat_err(input logic signed [WIDE_W-1:0] v);
    logic signed [ERR_W-1:0] r;
    if (v > WIDE_W'(ERR_MAX)) begin
      r = ERR_MAX;
    end else if (v < WIDE_W'(ERR_MIN)) begin
      r = ERR_MIN;
    end else begin
      r = ERR_W'(v);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/error_diffusion_binarizer_top.sv
// Top level of the error diffusion binarizer: configuration registers and the
// controller and datapath. Depends on edb_pkg, edb_ctrl and edb_dp.
`default_nettype none

// Channel  | Direction | Handshake          | Word
// in_      | input     | in_valid/in_stall  | edb_pkg::in_word_t (three samples, frame start)
// out_     | output    | out_valid/out_stall| edb_pkg::out_word_t (one bit per channel)
// cfg_     | input     | cfg_we             | cfg_index selects, cfg_wdata carries the value
//
// A pixel is worked one channel at a time: one channel in gray mode, three in colour mode.
// The shared divider lanes produce one quotient bit per cycle for every channel
// in turn.
// Reset is synchronous and active low; the registers return to their defaults.
// A result held by out_stall does not stop the next word being taken in; the
// pixel after it waits at its end until the result register is free.

module error_diffusion_binarizer_top (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire edb_pkg::in_word_t                 in_word,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output edb_pkg::out_word_t                     out_word,
  input  wire logic                              cfg_we,
  input  wire logic [edb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [edb_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  edb_pkg::cfg_t cfg_r;
  edb_pkg::cmd_t cmd;
  edb_pkg::sts_t sts;
  logic          busy;

  // Register file. The user must write only while the block is idle, so the
  // datapath sees stable settings for the whole of a pixel; nothing here enforces it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.threshold         <= edb_pkg::THR_W'(127);
      cfg_r.line_width        <= edb_pkg::LW_W'(640);
      cfg_r.color_mode        <= 1'b0;
      cfg_r.weight_right      <= edb_pkg::WGT_W'(7);
      cfg_r.weight_down_left  <= edb_pkg::WGT_W'(3);
      cfg_r.weight_down       <= edb_pkg::WGT_W'(5);
      cfg_r.weight_down_right <= edb_pkg::WGT_W'(1);
      cfg_r.weight_total      <= edb_pkg::TOT_W'(16);
    end else if (cfg_we) begin
      unique case (edb_pkg::cfg_idx_t'(cfg_index))
        edb_pkg::CFG_THRESHOLD:
          cfg_r.threshold <= cfg_wdata[edb_pkg::THR_W-1:0];
        edb_pkg::CFG_LINE_WIDTH:
          cfg_r.line_width <= cfg_wdata[edb_pkg::LW_W-1:0];
        edb_pkg::CFG_COLOR_MODE:
          cfg_r.color_mode <= cfg_wdata[0];
        edb_pkg::CFG_WEIGHT_RIGHT:
          cfg_r.weight_right <= cfg_wdata[edb_pkg::WGT_W-1:0];
        edb_pkg::CFG_WEIGHT_DOWN_LEFT:
          cfg_r.weight_down_left <= cfg_wdata[edb_pkg::WGT_W-1:0];
        edb_pkg::CFG_WEIGHT_DOWN:
          cfg_r.weight_down <= cfg_wdata[edb_pkg::WGT_W-1:0];
        edb_pkg::CFG_WEIGHT_DOWN_RIGHT:
          cfg_r.weight_down_right <= cfg_wdata[edb_pkg::WGT_W-1:0];
        edb_pkg::CFG_WEIGHT_TOTAL:
          cfg_r.weight_total <= cfg_wdata[edb_pkg::TOT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // The controller sequences each channel through adjust, multiply, the
  // divider steps and the two line store writes.
  edb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .sts      (sts),
    .busy     (busy),
    .cmd      (cmd)
  );

  // The datapath holds the carried errors, the line store and the result word.
  edb_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cmd       (cmd),
    .in_word   (in_word),
    .out_stall (out_stall),
    .sts       (sts),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

  // A new word is taken only when the controller has finished the last pixel.
  assign in_stall = busy;

endmodule

`default_nettype wire

>>> hw/rtl/edb_div.sv
// One lane of the restoring divider: divides the magnitude, then applies the sign; one bit a cycle while step is high.
// Depends on edb_pkg.
`default_nettype none

module edb_div (
  input  wire logic                             clk,
  input  wire logic                             load,
  input  wire logic                             step,
  input  wire logic [edb_pkg::MAG_W-1:0]        num,
  input  wire logic                             neg,
  input  wire logic [edb_pkg::TOT_W-1:0]        den,
  output logic signed [edb_pkg::QUO_W-1:0]      quot
);

  logic [edb_pkg::MAG_W-1:0] n_r, n_nxt;
  logic [edb_pkg::TOT_W-1:0] rem_r, rem_nxt;
  logic                      neg_r;
  logic [edb_pkg::TOT_W:0]   trial;
  logic [edb_pkg::TOT_W:0]   den_x;
  logic                      fits;

  always_comb begin
    trial   = {rem_r, n_r[edb_pkg::MAG_W-1]};
    den_x   = {1'b0, den};
    fits    = trial >= den_x;
    rem_nxt = fits ? edb_pkg::TOT_W'(trial - den_x) : edb_pkg::TOT_W'(trial);
    n_nxt   = {n_r[edb_pkg::MAG_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (load) begin
      n_r   <= num;
      rem_r <= '0;
      neg_r <= neg;
    end else if (step) begin
      n_r   <= n_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quot = neg_r ? -$signed({1'b0, n_r}) : $signed({1'b0, n_r});

endmodule

`default_nettype wire

>>> hw/rtl/edb_ctrl.sv
// Sequencing state machine: steps each pixel through its channels and the divider.
// Depends on edb_pkg.
`default_nettype none

module edb_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire edb_pkg::sts_t sts,
  output logic               busy,
  output edb_pkg::cmd_t      cmd
);

  edb_pkg::state_t           state_r, state_nxt;
  logic [edb_pkg::STEP_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      edb_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = edb_pkg::ST_ADJ;
      end
      edb_pkg::ST_ADJ: begin
        state_nxt = edb_pkg::ST_MUL;
      end
      edb_pkg::ST_MUL: begin
        state_nxt = edb_pkg::ST_DIV;
        cnt_nxt   = '0;
      end
      edb_pkg::ST_DIV: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == edb_pkg::STEP_W'(edb_pkg::DIV_STEPS - 1)) state_nxt = edb_pkg::ST_WRA;
      end
      edb_pkg::ST_WRA: begin
        state_nxt = edb_pkg::ST_WRB;
      end
      edb_pkg::ST_WRB: begin
        state_nxt = sts.last_ch ? edb_pkg::ST_DONE : edb_pkg::ST_ADJ;
      end
      edb_pkg::ST_DONE: begin
        if (sts.out_free) state_nxt = edb_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = edb_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state_r)
      edb_pkg::ST_IDLE: begin
        busy       = 1'b0;
        cmd.accept = in_valid;
      end
      edb_pkg::ST_ADJ:  cmd.adjust = 1'b1;
      edb_pkg::ST_MUL:  cmd.load = 1'b1;
      edb_pkg::ST_DIV:  cmd.step = 1'b1;
      edb_pkg::ST_WRA:  cmd.write_left = 1'b1;
      edb_pkg::ST_WRB: begin
        cmd.write_here = 1'b1;
        cmd.next_ch    = ~sts.last_ch;
      end
      edb_pkg::ST_DONE: cmd.finish = sts.out_free;
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= edb_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> state_r == edb_pkg::ST_ADJ)
    else $error("accepted word did not start the adjust step");

  a_finish_idles: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> (state_r == edb_pkg::ST_IDLE && !busy))
    else $error("finished pixel did not return to idle");

  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == edb_pkg::ST_DIV |-> cnt_r < edb_pkg::STEP_W'(edb_pkg::DIV_STEPS))
    else $error("divider step count overran");

endmodule

`default_nettype wire

>>> hw/rtl/edb_dp.sv
// Datapath: pixel capture, error adjustment, divider lanes, line store and result register.
// Depends on edb_pkg and edb_div.
`default_nettype none

module edb_dp (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire edb_pkg::cfg_t      cfg,
  input  wire edb_pkg::cmd_t      cmd,
  input  wire edb_pkg::in_word_t  in_word,
  input  wire logic               out_stall,
  output edb_pkg::sts_t           sts,
  output logic                    out_valid,
  output edb_pkg::out_word_t      out_word
);

  // Row position and frame state.
  logic [edb_pkg::COL_W-1:0]  col_r;
  logic                       first_r;
  logic [edb_pkg::COL_W-1:0]  x_r;
  logic                       last_r;
  logic [edb_pkg::CH_W-1:0]   ch_r;
  edb_pkg::in_word_t          pix_r;

  logic signed [edb_pkg::ERR_W-1:0] carry_r [edb_pkg::NUM_CH];
  logic signed [edb_pkg::ERR_W-1:0] pbl_r   [edb_pkg::NUM_CH];
  logic signed [edb_pkg::ERR_W-1:0] pb_r    [edb_pkg::NUM_CH];
  logic signed [edb_pkg::ERR_W-1:0] below_w [edb_pkg::NUM_CH];

  logic signed [edb_pkg::ERR_W-1:0] e_r;
  logic [edb_pkg::NUM_CH-1:0]       bits_r;
  logic                             out_valid_r;
  edb_pkg::out_word_t               out_word_r;

  logic [edb_pkg::LW_W-1:0]   w_eff;
  logic [edb_pkg::TOT_W-1:0]  den;
  logic [edb_pkg::LW_W-1:0]   col0;
  logic                       first0;
  logic                       wrap;
  logic                       clear_acc;
  logic [edb_pkg::COL_W-1:0]  x_acc;
  logic [edb_pkg::LW_W-1:0]   x_inc;

  always_comb begin
    if (cfg.line_width == '0) begin
      w_eff = edb_pkg::LW_W'(1);
    end else if (cfg.line_width > edb_pkg::LW_W'(edb_pkg::MAX_LW)) begin
      w_eff = edb_pkg::LW_W'(edb_pkg::MAX_LW);
    end else begin
      w_eff = cfg.line_width;
    end
    den       = (cfg.weight_total == '0) ? edb_pkg::TOT_W'(1) : cfg.weight_total;
    col0      = in_word.frame_start ? '0 : edb_pkg::LW_W'(col_r);
    first0    = in_word.frame_start | first_r;
    wrap      = col0 >= w_eff;
    clear_acc = in_word.frame_start | wrap;
    x_acc     = wrap ? '0 : col0[edb_pkg::COL_W-1:0];
    x_inc     = edb_pkg::LW_W'(x_acc) + 1'b1;
  end

  // Adjust step for the current channel.
  logic [edb_pkg::SAMP_W-1:0]        samp;
  logic signed [edb_pkg::WIDE_W-1:0] v_w, below_s, sum_w, thr_w, white_w, diff_w;
  logic signed [edb_pkg::ERR_W-1:0]  adj;
  logic                              on;
  logic signed [edb_pkg::ERR_W-1:0]  e_nxt;

  always_comb begin
    case (ch_r)
      2'd0:    samp = pix_r.red_or_gray;
      2'd1:    samp = pix_r.green;
      default: samp = pix_r.blue;
    endcase
    v_w     = $signed(edb_pkg::WIDE_W'(samp) << edb_pkg::FRAC_W);
    below_s = first_r ? '0 : edb_pkg::WIDE_W'(below_w[ch_r]);
    sum_w   = v_w + edb_pkg::WIDE_W'(carry_r[ch_r]) + below_s;
    adj     = edb_pkg::sat_err(sum_w);
    thr_w   = $signed(edb_pkg::WIDE_W'(cfg.threshold) << edb_pkg::FRAC_W);
    on      = edb_pkg::WIDE_W'(adj) > thr_w;
    white_w = $signed(edb_pkg::WIDE_W'(edb_pkg::WHITE));
    diff_w  = edb_pkg::WIDE_W'(adj) - (on ? white_w : '0);
    e_nxt   = edb_pkg::sat_err(diff_w);
  end

  // Divider lanes fed with |e| * weight.
  logic [edb_pkg::ERR_W-1:0]         mag;
  logic [edb_pkg::WGT_W-1:0]         wgt  [edb_pkg::NUM_LANES];
  logic [edb_pkg::MAG_W-1:0]         num  [edb_pkg::NUM_LANES];
  logic signed [edb_pkg::QUO_W-1:0]  quot [edb_pkg::NUM_LANES];

  always_comb begin
    mag = e_r[edb_pkg::ERR_W-1] ? edb_pkg::ERR_W'(-e_r) : edb_pkg::ERR_W'(e_r);
    wgt[edb_pkg::LANE_RIGHT]      = cfg.weight_right;
    wgt[edb_pkg::LANE_DOWN_LEFT]  = cfg.weight_down_left;
    wgt[edb_pkg::LANE_DOWN]       = cfg.weight_down;
    wgt[edb_pkg::LANE_DOWN_RIGHT] = cfg.weight_down_right;
  end

  for (genvar k = 0; k < edb_pkg::NUM_LANES; k++) begin : g_lane
    assign num[k] = edb_pkg::MAG_W'(mag) * edb_pkg::MAG_W'(wgt[k]);
    edb_div u_div (
      .clk  (clk),
      .load (cmd.load),
      .step (cmd.step),
      .num  (num[k]),
      .neg  (e_r[edb_pkg::ERR_W-1]),
      .den  (den),
      .quot (quot[k])
    );
  end

  // Share updates.
  logic signed [edb_pkg::ERR_W-1:0] left_val, np1, np0, carry_new;
  logic signed [edb_pkg::WIDE_W-1:0] pb_use;

  always_comb begin
    left_val  = edb_pkg::sat_err(edb_pkg::WIDE_W'(pbl_r[ch_r])
                + edb_pkg::WIDE_W'(quot[edb_pkg::LANE_DOWN_LEFT]));
    pb_use    = (x_r != '0) ? edb_pkg::WIDE_W'(pb_r[ch_r]) : '0;
    np1       = edb_pkg::sat_err(pb_use + edb_pkg::WIDE_W'(quot[edb_pkg::LANE_DOWN]));
    np0       = last_r ? '0
                : edb_pkg::sat_err(edb_pkg::WIDE_W'(quot[edb_pkg::LANE_DOWN_RIGHT]));
    carry_new = last_r ? '0
                : edb_pkg::sat_err(edb_pkg::WIDE_W'(quot[edb_pkg::LANE_RIGHT]));
  end

  // Line store: one array per channel so a gray pixel leaves the others untouched.
  logic [edb_pkg::COL_W-1:0]        wr_addr;
  logic signed [edb_pkg::ERR_W-1:0] wr_data;
  logic                             wr_any;

  always_comb begin
    wr_addr = cmd.write_left ? x_r - 1'b1 : x_r;
    wr_data = cmd.write_left ? left_val : pbl_r[ch_r];
    wr_any  = (cmd.write_left && x_r != '0) || (cmd.write_here && last_r);
  end

  for (genvar c = 0; c < edb_pkg::NUM_CH; c++) begin : g_store
    logic [edb_pkg::ERR_W-1:0] mem [edb_pkg::MAX_LW];
    logic [edb_pkg::ERR_W-1:0] rdata_r;
    always_ff @(posedge clk) begin
      if (wr_any && ch_r == edb_pkg::CH_W'(c)) mem[wr_addr] <= wr_data;
      if (cmd.accept) rdata_r <= mem[x_acc];
    end
    assign below_w[c] = $signed(rdata_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pix_r  <= in_word;
      x_r    <= x_acc;
      last_r <= x_inc >= w_eff;
    end
    if (cmd.adjust) e_r <= e_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      first_r     <= 1'b1;
      ch_r        <= '0;
      bits_r      <= '0;
      out_valid_r <= 1'b0;
      for (int c = 0; c < edb_pkg::NUM_CH; c++) begin
        carry_r[c] <= '0;
        pbl_r[c]   <= '0;
        pb_r[c]    <= '0;
      end
    end else begin
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      if (cmd.accept) begin
        first_r <= wrap ? 1'b0 : first0;
        ch_r    <= '0;
        bits_r  <= '0;
        if (clear_acc) begin
          for (int c = 0; c < edb_pkg::NUM_CH; c++) begin
            carry_r[c] <= '0;
            pbl_r[c]   <= '0;
            pb_r[c]    <= '0;
          end
        end
      end
      if (cmd.adjust) bits_r[ch_r] <= on;
      if (cmd.write_left) begin
        pbl_r[ch_r]   <= np1;
        pb_r[ch_r]    <= np0;
        carry_r[ch_r] <= carry_new;
      end
      if (cmd.next_ch) ch_r <= ch_r + 1'b1;
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
        if (last_r) begin
          col_r   <= '0;
          first_r <= 1'b0;
          for (int c = 0; c < edb_pkg::NUM_CH; c++) begin
            carry_r[c] <= '0;
            pbl_r[c]   <= '0;
            pb_r[c]    <= '0;
          end
        end else begin
          col_r <= x_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_word_r.red_or_gray_bit <= bits_r[0];
      out_word_r.green_bit       <= bits_r[1];
      out_word_r.blue_bit        <= bits_r[2];
    end
  end

  assign sts.last_ch  = cfg.color_mode ? (ch_r == edb_pkg::CH_W'(edb_pkg::NUM_CH - 1)) : 1'b1;
  assign sts.out_free = ~out_valid_r | ~out_stall;
  assign out_valid    = out_valid_r;
  assign out_word     = out_word_r;

  a_finish_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_valid_r)
    else $error("finished pixel produced no result");

endmodule

`default_nettype wire
